@@ sv/fcg_pkg.sv @@
// Shared types and constants for the four-corner gradient pixel unit.
// Holds RGB565 channel extraction, corner ordering and register indexes.
// No dependencies.
package fcg_pkg;

	localparam int PIX_W    = 16;   // RGB565 word
	localparam int COORD_W  = 11;   // col / row
	localparam int DIMREG_W = 12;   // image_width / image_height registers
	localparam int CH_N     = 3;    // red, green, blue
	localparam int CH_W     = 6;    // widest channel (green)
	localparam int CH_RB_W  = 5;    // red and blue width
	localparam int CORNER_N = 4;

	// corner order inside corners_t and the weight vector
	localparam int CN_TL = 0;
	localparam int CN_TR = 1;
	localparam int CN_BL = 2;
	localparam int CN_BR = 3;

	// channel order inside the sum and quotient vectors
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	typedef enum logic [2:0] {
		REG_TL     = 3'd0,
		REG_TR     = 3'd1,
		REG_BL     = 3'd2,
		REG_BR     = 3'd3,
		REG_WIDTH  = 3'd4,
		REG_HEIGHT = 3'd5
	} reg_idx_t;

	typedef logic [CORNER_N-1:0][PIX_W-1:0] corners_t;
	typedef logic [CH_W-1:0] chan_t;

	// one channel of an RGB565 word, zero-extended to CH_W
	function automatic chan_t chan_of(input logic [PIX_W-1:0] pix, input int ch);
		chan_t c;
		case (ch)
			CH_RED: begin
				c = {1'b0, pix[15:11]};
			end
			CH_GREEN: begin
				c = pix[10:5];
			end
			default: begin
				c = {1'b0, pix[4:0]};
			end
		endcase
		return c;
	endfunction

endpackage

@@ sv/fcg_weight.sv @@
// Coordinate clamp (stage 1) and bilinear corner weights (stage 2).
// Depends on fcg_pkg.
module fcg_weight #(
	parameter int DW = 11
) (
	input  logic                                      clk,
	input  logic [1:0]                                adv,
	input  logic [fcg_pkg::COORD_W-1:0]               col,
	input  logic [fcg_pkg::COORD_W-1:0]               row,
	input  logic [DW-1:0]                             w1,
	input  logic [DW-1:0]                             h1,
	output logic [fcg_pkg::CORNER_N-1:0][2*DW-1:0]    wgt_s2,
	output logic [2*DW-1:0]                           den_s2
);
	import fcg_pkg::*;

	localparam int PW = 2 * DW;
	localparam int XW = (DW > COORD_W) ? DW : COORD_W;

	logic [DW-1:0] x_d;
	logic [DW-1:0] y_d;
	logic [DW-1:0] x_s1;
	logic [DW-1:0] y_s1;
	logic [DW-1:0] xr_s1;
	logic [DW-1:0] yr_s1;
	logic [DW-1:0] w1_s1;
	logic [DW-1:0] h1_s1;

	// saturate coordinates to the last column / row
	always_comb begin
		x_d = (XW'(col) > XW'(w1)) ? w1 : DW'(col);
		y_d = (XW'(row) > XW'(h1)) ? h1 : DW'(row);
	end

	// stage 1: clamped coordinates and their distances to the far edge
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			x_s1  <= x_d;
			y_s1  <= y_d;
			xr_s1 <= w1 - x_d;
			yr_s1 <= h1 - y_d;
			w1_s1 <= w1;
			h1_s1 <= h1;
		end
	end

	// stage 2: area weights of the four corners and the common divisor
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			wgt_s2[CN_TL] <= PW'(xr_s1) * PW'(yr_s1);
			wgt_s2[CN_TR] <= PW'(x_s1) * PW'(yr_s1);
			wgt_s2[CN_BL] <= PW'(xr_s1) * PW'(y_s1);
			wgt_s2[CN_BR] <= PW'(x_s1) * PW'(y_s1);
			den_s2        <= PW'(w1_s1) * PW'(h1_s1);
		end
	end

endmodule

@@ sv/fcg_blend.sv @@
// Weighted corner sum per color channel (stage 3).
// Depends on fcg_pkg.
module fcg_blend #(
	parameter int DW = 11
) (
	input  logic                                                   clk,
	input  logic                                                   adv,
	input  fcg_pkg::corners_t                                      corners,
	input  logic [fcg_pkg::CORNER_N-1:0][2*DW-1:0]                 wgt,
	input  logic [2*DW-1:0]                                        den,
	output logic [fcg_pkg::CH_N-1:0][2*DW+fcg_pkg::CH_W-1:0]       sum_s3,
	output logic [2*DW-1:0]                                        den_s3
);
	import fcg_pkg::*;

	localparam int PW = 2 * DW;
	localparam int SW = PW + CH_W;

	logic [CH_N-1:0][SW-1:0] sum_d;

	// four small products per channel; the total never exceeds 63 * den
	always_comb begin
		for (int ch = 0; ch < CH_N; ch++) begin
			sum_d[ch] = '0;
			for (int cn = 0; cn < CORNER_N; cn++) begin
				sum_d[ch] = sum_d[ch] + SW'(chan_of(corners[cn], ch)) * SW'(wgt[cn]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= sum_d;
			den_s3 <= den;
		end
	end

endmodule

@@ sv/fcg_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, all channels in parallel.
// Quotient is below 2**CH_W since each sum is at most the channel max times den.
// Depends on fcg_pkg.
module fcg_div #(
	parameter int DW = 11
) (
	input  logic                                                   clk,
	input  logic [fcg_pkg::CH_W-1:0]                               adv,
	input  logic [fcg_pkg::CH_N-1:0][2*DW+fcg_pkg::CH_W-1:0]       sum,
	input  logic [2*DW-1:0]                                        den,
	output logic [fcg_pkg::CH_N-1:0][fcg_pkg::CH_W-1:0]            quo
);
	import fcg_pkg::*;

	localparam int PW = 2 * DW;
	localparam int SW = PW + CH_W;

	logic [CH_N-1:0][SW-1:0]   rem_s [0:CH_W-2];
	logic [PW-1:0]             den_s [0:CH_W-2];
	logic [CH_N-1:0][CH_W-1:0] q_s   [0:CH_W-1];

	for (genvar k = 0; k < CH_W; k++) begin : g_bit
		localparam int B = CH_W - 1 - k;

		logic [CH_N-1:0][SW-1:0]   rem_in;
		logic [CH_N-1:0][CH_W-1:0] q_in;
		logic [CH_N-1:0][CH_W-1:0] q_d;
		logic [CH_N-1:0]           ge;
		logic [PW-1:0]             den_in;
		logic [SW-1:0]             den_sh;

		if (k == 0) begin : g_head
			assign rem_in = sum;
			assign q_in   = '0;
			assign den_in = den;
		end else begin : g_body
			assign rem_in = rem_s[k-1];
			assign q_in   = q_s[k-1];
			assign den_in = den_s[k-1];
		end

		assign den_sh = SW'(den_in) << B;

		// trial compare and quotient bit, MSB first
		always_comb begin
			for (int ch = 0; ch < CH_N; ch++) begin
				ge[ch]  = (rem_in[ch] >= den_sh);
				q_d[ch] = {q_in[ch][CH_W-2:0], ge[ch]};
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				q_s[k] <= q_d;
			end
		end

		// partial remainder only goes on where another bit follows
		if (k < CH_W - 1) begin : g_carry
			logic [CH_N-1:0][SW-1:0] rem_d;

			always_comb begin
				for (int ch = 0; ch < CH_N; ch++) begin
					rem_d[ch] = ge[ch] ? (rem_in[ch] - den_sh) : rem_in[ch];
				end
			end

			always_ff @(posedge clk) begin
				if (adv[k]) begin
					rem_s[k] <= rem_d;
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign quo = q_s[CH_W-1];

endmodule

@@ sv/four_corner_gradient_pixel_unit.sv @@
// Four-corner bilinear gradient, BGR565 out (red in the low bits). Stages from accept
// to output valid: clamp, weights, corner sum, then one quotient bit per stage.
// Throughput: one word per cycle; a stall holds each full stage, bubbles close up.
// Reset (arst_n low, asynchronous): pipeline empty, corners 0, size 2 x 2.
// Depends on fcg_pkg, fcg_weight, fcg_blend, fcg_div.
module four_corner_gradient_pixel_unit #(
	parameter int MAX_DIM = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // col [10:0], row [21:11], zero [23:22]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // red [4:0], green [10:5], blue [15:11]
);
	import fcg_pkg::*;

	localparam int DW  = $clog2(MAX_DIM);
	localparam int PW  = 2 * DW;
	localparam int SW  = PW + CH_W;
	localparam int DCW = (DW + 1 > DIMREG_W) ? DW + 1 : DIMREG_W;
	localparam int NST = 3 + CH_W;
	localparam logic [DCW-1:0] DIM_MIN = DCW'(2);
	localparam logic [DCW-1:0] DIM_MAX = DCW'(MAX_DIM);

	corners_t              corners_q;
	logic [DIMREG_W-1:0]   width_q;
	logic [DIMREG_W-1:0]   height_q;
	logic [DCW-1:0]        wd;
	logic [DCW-1:0]        hd;
	logic [DW-1:0]         w1;
	logic [DW-1:0]         h1;
	logic [NST-1:0]        vld_q;
	logic [NST-1:0]        adv;

	logic [CORNER_N-1:0][PW-1:0] wgt_s2;
	logic [PW-1:0]               den_s2;
	logic [CH_N-1:0][SW-1:0]     sum_s3;
	logic [PW-1:0]               den_s3;
	logic [CH_N-1:0][CH_W-1:0]   quo;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corners_q <= '0;
			width_q   <= DIMREG_W'(2);
			height_q  <= DIMREG_W'(2);
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_TL: begin
					corners_q[CN_TL] <= wr_data;
				end
				REG_TR: begin
					corners_q[CN_TR] <= wr_data;
				end
				REG_BL: begin
					corners_q[CN_BL] <= wr_data;
				end
				REG_BR: begin
					corners_q[CN_BR] <= wr_data;
				end
				REG_WIDTH: begin
					width_q <= wr_data[DIMREG_W-1:0];
				end
				REG_HEIGHT: begin
					height_q <= wr_data[DIMREG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// size limited to 2..MAX_DIM, then last column / row index
	always_comb begin
		wd = DCW'(width_q);
		if (wd < DIM_MIN) begin
			wd = DIM_MIN;
		end else if (wd > DIM_MAX) begin
			wd = DIM_MAX;
		end
		hd = DCW'(height_q);
		if (hd < DIM_MIN) begin
			hd = DIM_MIN;
		end else if (hd > DIM_MAX) begin
			hd = DIM_MAX;
		end
		w1 = DW'(wd - DCW'(1));
		h1 = DW'(hd - DCW'(1));
	end

	// a stage moves when it is empty or the next one moves
	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || m_tready;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = adv[0];
	assign m_tvalid = vld_q[NST-1];

	fcg_weight #(
		.DW(DW)
	) u_weight (
		.clk    (clk),
		.adv    (adv[1:0]),
		.col    (s_tdata[10:0]),
		.row    (s_tdata[21:11]),
		.w1     (w1),
		.h1     (h1),
		.wgt_s2 (wgt_s2),
		.den_s2 (den_s2)
	);

	fcg_blend #(
		.DW(DW)
	) u_blend (
		.clk     (clk),
		.adv     (adv[2]),
		.corners (corners_q),
		.wgt     (wgt_s2),
		.den     (den_s2),
		.sum_s3  (sum_s3),
		.den_s3  (den_s3)
	);

	fcg_div #(
		.DW(DW)
	) u_div (
		.clk (clk),
		.adv (adv[NST-1:3]),
		.sum (sum_s3),
		.den (den_s3),
		.quo (quo)
	);

	assign m_tdata = {quo[CH_BLUE][CH_RB_W-1:0], quo[CH_GREEN], quo[CH_RED][CH_RB_W-1:0]};

	// an empty output stage never blocks the input
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked while output stage empty");

	// a full pipe with a stalled output takes nothing new
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !m_tready |-> !s_tready)
		else $error("input accepted into full stalled pipeline");

	// an accepted word lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted word lost at first stage");

	// 5-bit channels never produce a quotient of 32 or more
	a_rb_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !quo[CH_RED][CH_W-1] && !quo[CH_BLUE][CH_W-1])
		else $error("red or blue quotient out of range");

endmodule
